### sv/tts_pkg.sv
// shared types, character codes and character class helpers for the token splitter
// no dependencies
package tts_pkg;

  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_WORD  = 3'd1,
    CLS_UNDER = 3'd2,
    CLS_NUM   = 3'd3,
    CLS_WS    = 3'd4,
    CLS_CR    = 3'd5,
    CLS_ESC   = 3'd6
  } token_class_t;

  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NONE   = 8'h00;

  // one result byte
  typedef struct packed {
    logic [7:0] ch;
    logic       start;
    logic       last;
  } res_t;

  // everything one request produces: results and the next tokeniser state
  typedef struct packed {
    logic [1:0]   n;
    res_t         r0;
    res_t         r1;
    token_class_t cls;
    logic [7:0]   first;
    logic [7:0]   pend;
  } step_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
  endfunction

  function automatic logic is_wordish(input logic [7:0] c);
    return is_letter(c) || c == CH_UNDER;
  endfunction

  // class of a token that opens with byte c
  function automatic token_class_t open_class(input logic [7:0] c);
    token_class_t k;
    if (is_letter(c)) k = CLS_WORD;
    else if (c == CH_UNDER) k = CLS_UNDER;
    else if (is_digit(c)) k = CLS_NUM;
    else if (c == CH_BSLASH) k = CLS_ESC;
    else if (c == CH_CR) k = CLS_CR;
    else if (c == CH_TAB || c == CH_LF) k = CLS_NONE;
    else if (is_space(c)) k = CLS_WS;
    else k = CLS_NONE;
    return k;
  endfunction

endpackage

### sv/tts_step.sv
// token decision logic: one registered request plus current state gives up to two results
// depends on tts_pkg
module tts_step (
  input  logic [7:0]           ch,
  input  logic                 eos,
  input  tts_pkg::token_class_t cls,
  input  logic [7:0]           first,
  input  logic [7:0]           pend,
  output tts_pkg::step_t       step
);
  import tts_pkg::*;

  logic joins;

  always_comb begin
    joins = (cls == CLS_NUM) ? is_digit(ch) : is_wordish(ch);

    step       = '0;
    step.cls   = cls;
    step.first = first;
    step.pend  = pend;

    if (eos) begin
      if (pend != CH_NONE) begin
        step.n  = 2'd1;
        step.r0 = '{ch: pend, start: 1'b1, last: 1'b1};
      end
      step.pend = CH_NONE;
      step.cls  = CLS_NONE;
    end else if (pend != CH_NONE) begin
      // held byte is decided by this one
      step.n    = 2'd2;
      step.r0   = '{ch: pend, start: !joins, last: 1'b0};
      step.r1   = '{ch: ch, start: !joins, last: 1'b1};
      step.pend = CH_NONE;
      if (!joins) begin
        step.cls   = open_class(ch);
        step.first = ch;
      end
    end else begin
      step.n  = 2'd1;
      step.r0 = '{ch: ch, start: 1'b1, last: 1'b1};
      case (cls)
        CLS_WORD, CLS_UNDER: begin
          if (is_wordish(ch)) begin
            step.r0.start = 1'b0;
          end else if (cls == CLS_WORD && ch == CH_APOS) begin
            step.n    = 2'd0;
            step.r0   = '0;
            step.pend = ch;
          end else begin
            step.cls   = open_class(ch);
            step.first = ch;
          end
        end
        CLS_NUM: begin
          if (is_digit(ch)) begin
            step.r0.start = 1'b0;
          end else if (ch == CH_PERIOD || ch == CH_COMMA) begin
            step.n    = 2'd0;
            step.r0   = '0;
            step.pend = ch;
          end else begin
            step.cls   = open_class(ch);
            step.first = ch;
          end
        end
        CLS_WS: begin
          if (ch == first) begin
            step.r0.start = 1'b0;
          end else begin
            step.cls   = open_class(ch);
            step.first = ch;
          end
        end
        CLS_CR: begin
          if (ch == CH_LF) begin
            step.r0.start = 1'b0;
            step.cls      = CLS_NONE;
          end else begin
            step.cls   = open_class(ch);
            step.first = ch;
          end
        end
        CLS_ESC: begin
          step.r0.start = 1'b0;
          step.cls      = CLS_NONE;
        end
        default: begin
          step.cls   = open_class(ch);
          step.first = ch;
        end
      endcase
    end
  end

endmodule

### sv/tts_out_buf.sv
// two-slot result register that drains one result per cycle onto the master stream while m_axis_tready is high
// depends on tts_pkg
module tts_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  tts_pkg::step_t step,
  output logic           space,
  output logic [7:0]     m_axis_tdata,  // out_char
  output logic           m_axis_tuser,  // token_start
  output logic           m_axis_tlast,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready
);
  import tts_pkg::*;

  logic [1:0] cnt;
  res_t       slot0;
  res_t       slot1;
  logic       pop;

  assign m_axis_tvalid = cnt != 2'd0;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign space         = (cnt == 2'd0) || (cnt == 2'd1 && m_axis_tready);
  assign m_axis_tdata  = slot0.ch;
  assign m_axis_tuser  = slot0.start;
  assign m_axis_tlast  = slot0.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= step.n;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= step.r0;
      slot1 <= step.r1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

### sv/text_token_splitter_top.sv
// text token splitter: re-emits each byte with a token-start flag
// path: a request is registered, then decided into the result register that drives m_axis
// throughput: one byte per cycle while m_axis_tready is high; a byte that releases a held
// separator gives two results and holds the input until the first has drained; a held separator gives no result
// reset (rst, synchronous, active high): no open token, nothing held, both stages empty
module text_token_splitter_top (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] s_axis_tdata,   // in_char
  input  logic       s_axis_tuser,   // end_of_stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_char
  output logic       m_axis_tuser,   // token_start
  output logic       m_axis_tlast,   // last result of this request
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready
);
  import tts_pkg::*;

  // input register: decouples the slave side from the result register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_eos;
  logic       in_take;

  // tokeniser state
  token_class_t cls;
  logic [7:0]   first;
  logic [7:0]   pend;

  step_t step;
  logic  space;

  // the registered request moves on once the result register has room for its results
  assign in_take       = in_valid && space;
  assign s_axis_tready = !in_valid || in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char <= s_axis_tdata;
      in_eos  <= s_axis_tuser;
    end
  end

  tts_step u_step (
    .ch    (in_char),
    .eos   (in_eos),
    .cls   (cls),
    .first (first),
    .pend  (pend),
    .step  (step)
  );

  // state advances together with the load of the results
  always_ff @(posedge clk) begin
    if (rst) begin
      cls   <= CLS_NONE;
      first <= CH_NONE;
      pend  <= CH_NONE;
    end else if (in_take) begin
      cls   <= step.cls;
      first <= step.first;
      pend  <= step.pend;
    end
  end

  tts_out_buf u_out_buf (
    .clk           (clk),
    .rst           (rst),
    .load          (in_take),
    .step          (step),
    .space         (space),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // a held byte only ever sits inside a letter-led token or a number
  a_pend_class : assert property (@(posedge clk) disable iff (rst)
    pend != CH_NONE |-> (cls == CLS_WORD || cls == CLS_NUM))
    else $error("held byte outside a word or number token");

  // end of stream always closes the open token and flushes out any held byte
  a_eos_close : assert property (@(posedge clk) disable iff (rst)
    in_take && in_eos |=> (cls == CLS_NONE && pend == CH_NONE))
    else $error("end of stream left token state open");

  // a stalled request stays in the input register unchanged
  a_in_hold : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_take |=> in_valid && $stable(in_char) && $stable(in_eos))
    else $error("registered request lost while stalled");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for text_token_splitter_top: random and directed text streams,
// each emitted byte checked against a token-start predictor built into this file
// depends on tts_pkg (token classes, character codes) and the top level rtl
module testbench;
  import tts_pkg::*;

  localparam int TEXT_LEN    = 1600;    // minimum random requests after the directed part
  localparam int QUIET_TAIL  = 150;     // last requests run with no new idling started on either side
  localparam int HOLD_AT     = 400;     // accepted requests before the long receiver hold-off
  localparam int HOLD_LEN    = 300;     // cycles of that hold-off
  localparam int DRAIN_WAIT  = 8;       // margin after the two-stage splitter path
  localparam int CYCLE_LIMIT = 400000;

  // one request: a text byte, or an end-of-stream marker
  typedef struct {
    logic [7:0] ch;
    logic       eos;
  } text_req_t;

  // one emitted byte with its token mark
  typedef struct packed {
    logic [7:0] ch;
    logic       start;
    logic       last;
  } mark_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] s_axis_tdata = 8'h00;   // in_char
  logic       s_axis_tuser = 1'b0;    // end_of_stream
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] m_axis_tdata;           // out_char
  logic       m_axis_tuser;           // token_start
  logic       m_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;

  text_req_t text_q[$];         // requests still to be offered
  mark_t     marked_bytes_q[$]; // bytes the splitter owes us, oldest first

  // predictor state: open token class, its first byte, and the held separator
  token_class_t tok_cls = CLS_NONE;
  logic [7:0]   tok_first = 8'h00;
  logic [7:0]   held_sep = CH_NONE;

  int n_total, n_reqs_in, n_eos, n_bytes_out, n_starts, n_pairs, n_flushes, n_errors;
  int unsigned cycles;
  logic req_taken = 1'b0;
  int gap_cnt, stall_cnt, hold_cnt;
  int tx_rate = 3, rx_rate = 3;   // idling odds out of 16, re-picked now and then
  logic held_once = 1'b0;
  text_req_t cur_req;
  mark_t want;

  text_token_splitter_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // character classes, ascii only
  function automatic logic alpha_byte(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic space_byte(input logic [7:0] c);
    return (c inside {[CH_TAB:CH_CR], CH_SPACE});
  endfunction

  function automatic logic name_byte(input logic [7:0] c);
    return alpha_byte(c) || c == CH_UNDER;
  endfunction

  // class of the token that a byte opens; tab and lf stand alone like other bytes
  function automatic token_class_t class_of(input logic [7:0] c);
    if (alpha_byte(c)) return CLS_WORD;
    if (c == CH_UNDER) return CLS_UNDER;
    if (digit_byte(c)) return CLS_NUM;
    if (c == CH_BSLASH) return CLS_ESC;
    if (c == CH_CR) return CLS_CR;
    if (c == CH_TAB || c == CH_LF) return CLS_NONE;
    if (space_byte(c)) return CLS_WS;
    return CLS_NONE;
  endfunction

  // advance the token state by one request and queue the bytes it releases
  function automatic void split_byte(input logic [7:0] c, input logic eos);
    mark_t res [2];
    int    n;
    logic  joins, st, emitted;
    n = 0;
    if (eos) begin
      // flush a held separator alone, then close whatever is open
      if (held_sep != CH_NONE) begin
        res[0] = '{held_sep, 1'b1, 1'b0};
        n = 1;
        n_flushes++;
      end
      held_sep = CH_NONE;
      tok_cls = CLS_NONE;
    end else if (held_sep != CH_NONE) begin
      // the new byte decides: both continue the token, or both start fresh ones
      joins = (tok_cls == CLS_NUM) ? digit_byte(c) : name_byte(c);
      res[0] = '{held_sep, !joins, 1'b0};
      res[1] = '{c, !joins, 1'b0};
      n = 2;
      if (!joins) begin
        tok_cls = class_of(c);
        tok_first = c;
      end
      held_sep = CH_NONE;
    end else begin
      emitted = 1'b1;
      st = 1'b1;
      case (tok_cls)
        CLS_WORD, CLS_UNDER: begin
          if (name_byte(c)) st = 1'b0;
          else if (tok_cls == CLS_WORD && c == CH_APOS) begin
            held_sep = c;
            emitted = 1'b0;
          end
        end
        CLS_NUM: begin
          if (digit_byte(c)) st = 1'b0;
          else if (c == CH_PERIOD || c == CH_COMMA) begin
            held_sep = c;
            emitted = 1'b0;
          end
        end
        CLS_WS: begin
          if (c == tok_first) st = 1'b0;
        end
        CLS_CR: begin
          // cr takes one lf and the token ends there
          if (c == CH_LF) begin
            st = 1'b0;
            tok_cls = CLS_NONE;
          end
        end
        CLS_ESC: begin
          // whatever follows a backslash belongs to it
          st = 1'b0;
          tok_cls = CLS_NONE;
        end
        default: ;
      endcase
      if (emitted) begin
        res[0] = '{c, st, 1'b0};
        n = 1;
        if (st) begin
          tok_cls = class_of(c);
          tok_first = c;
        end
      end
    end
    if (n == 2) n_pairs++;
    for (int i = 0; i < n; i++) begin
      res[i].last = (i == n - 1);
      marked_bytes_q.push_back(res[i]);
    end
  endfunction

  function automatic void add_byte(input logic [7:0] c);
    text_q.push_back('{c, 1'b0});
  endfunction

  // in_char is ignored with end_of_stream, so it carries random junk
  function automatic void add_eos();
    text_q.push_back('{8'($urandom_range(0, 255)), 1'b1});
  endfunction

  function automatic logic [7:0] any_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
                                : 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'($urandom_range(8'h30, 8'h39));
  endfunction

  // stimulus: directed corner cases first, then random well-formed text with noise
  initial begin
    int kind, len, r;
    logic [7:0] ws;

    // byte extremes, each standing alone
    add_byte(8'h00);
    add_byte(8'hFF);
    // apostrophe inside a word joins it
    add_byte("I"); add_byte(CH_APOS); add_byte("d");
    // second apostrophe after a held one: both stand alone
    add_byte("x"); add_byte(CH_APOS); add_byte(CH_APOS);
    // number with a joined period, then a separator followed by another separator
    add_byte("9"); add_byte(CH_PERIOD); add_byte("5"); add_byte(CH_COMMA); add_byte(CH_COMMA);
    // whitespace run broken by a different blank
    add_byte(CH_SPACE); add_byte(CH_SPACE); add_byte(8'h0B);
    // cr takes one lf only
    add_byte(CH_CR); add_byte(CH_LF); add_byte(CH_LF);
    add_byte(CH_TAB);
    // escape swallows a high byte
    add_byte(CH_BSLASH); add_byte(8'h80);
    // underscore-led token never holds an apostrophe
    add_byte(CH_UNDER); add_byte(CH_APOS);
    // held apostrophe flushed by end of stream, then end of stream with nothing held
    add_byte("z"); add_byte(CH_APOS); add_eos();
    add_eos();

    n_total = text_q.size() + TEXT_LEN;
    while (text_q.size() < n_total) begin
      kind = $urandom_range(0, 11);
      case (kind)
        0, 1, 2, 3: begin
          // word, letter-led or underscore-led, with the odd apostrophe
          add_byte((kind == 3) ? CH_UNDER : any_letter());
          len = $urandom_range(0, 6);
          for (int j = 0; j < len; j++) begin
            r = $urandom_range(0, 9);
            add_byte((r == 0) ? CH_APOS : (r == 1) ? CH_UNDER : any_letter());
          end
        end
        4, 5: begin
          // number with periods and commas scattered in
          add_byte(any_digit());
          len = $urandom_range(0, 6);
          for (int j = 0; j < len; j++) begin
            r = $urandom_range(0, 7);
            add_byte((r == 0) ? CH_PERIOD : (r == 1) ? CH_COMMA : any_digit());
          end
        end
        6: begin
          r = $urandom_range(0, 4);
          ws = (r == 0) ? 8'h0B : (r == 1) ? 8'h0C : (r == 2) ? CH_TAB :
               (r == 3) ? CH_LF : CH_SPACE;
          len = $urandom_range(1, 5);
          for (int j = 0; j < len; j++) add_byte(ws);
        end
        7: begin
          add_byte(CH_CR);
          r = $urandom_range(0, 2);
          for (int j = 0; j < r; j++) add_byte(CH_LF);
        end
        8: begin
          add_byte(CH_BSLASH);
          add_byte(8'($urandom_range(0, 255)));
        end
        9: add_eos();
        default: begin
          len = $urandom_range(1, 3);
          for (int j = 0; j < len; j++) add_byte(8'($urandom_range(0, 255)));
        end
      endcase
    end
    n_total = text_q.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every request in, every byte back, then a short drain for stray output
    while (n_reqs_in < n_total) @(posedge clk);
    while (marked_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d requests (%0d end of stream) and checked %0d bytes, %0d token starts",
             n_reqs_in, n_eos, n_bytes_out, n_starts);
    $display("%0d requests released a held separator, %0d held separators flushed at end",
             n_pairs, n_flushes);
    if (n_errors == 0) begin
      $display("text_token_splitter_top test passed");
    end else begin
      $display("text_token_splitter_top test failed");
    end
    $finish;
  end

  // sender: offers the next request at the falling edge once the last one was taken,
  // with random idle gaps while more than QUIET_TAIL requests remain
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      req_taken = 1'b0;
      if ($urandom_range(0, 255) == 0) tx_rate = $urandom_range(0, 4);
      if (gap_cnt > 0) begin
        gap_cnt--;
        s_axis_tvalid <= 1'b0;
      end else if (text_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (text_q.size() > QUIET_TAIL && tx_rate != 0 &&
                   $urandom_range(0, 15) < tx_rate) begin
        gap_cnt = $urandom_range(0, 11);
        s_axis_tvalid <= 1'b0;
      end else begin
        cur_req = text_q.pop_front();
        s_axis_tdata  <= cur_req.ch;
        s_axis_tuser  <= cur_req.eos;
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off so the splitter backs up
  // and has to refuse requests while the sender keeps offering
  always @(negedge clk) begin
    if ($urandom_range(0, 255) == 0) rx_rate = $urandom_range(0, 4);
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (!held_once && n_reqs_in >= HOLD_AT) begin
      held_once = 1'b1;
      hold_cnt = HOLD_LEN - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      m_axis_tready <= 1'b0;
    end else if (text_q.size() > QUIET_TAIL && rx_rate != 0 &&
                 $urandom_range(0, 15) < rx_rate) begin
      stall_cnt = $urandom_range(0, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor: accepted requests feed the predictor, accepted bytes are checked
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      split_byte(s_axis_tdata, s_axis_tuser);
      n_reqs_in++;
      if (s_axis_tuser) n_eos++;
      req_taken = 1'b1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_bytes_out++;
      if (m_axis_tuser) n_starts++;
      if (marked_bytes_q.size() == 0) begin
        $display("%0t: byte with nothing expected: out_char %h token_start %b last %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        n_errors++;
      end else begin
        want = marked_bytes_q.pop_front();
        if (m_axis_tdata !== want.ch) begin
          $display("%0t: out_char expected %h, got %h", $time, want.ch, m_axis_tdata);
          n_errors++;
        end
        if (m_axis_tuser !== want.start) begin
          $display("%0t: token_start for %h expected %b, got %b",
                   $time, want.ch, want.start, m_axis_tuser);
          n_errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last for %h expected %b, got %b",
                   $time, want.ch, want.last, m_axis_tlast);
          n_errors++;
        end
      end
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles, %0d requests in, %0d bytes owed",
               $time, cycles, n_reqs_in, marked_bytes_q.size());
      $display("text_token_splitter_top test failed");
      $finish;
    end
  end

endmodule
